// File: rtl/ofp_pkg.sv
// Shared types and constants for the optical-flow frame parser.
package ofp_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] SOURCE_RESET = 8'h22;
  localparam logic [7:0] FUNC_FLOW    = 8'h51;
  localparam logic [7:0] FUNC_HEIGHT  = 8'h52;
  localparam logic [7:0] MODE_RAW     = 8'h00;
  localparam logic [7:0] MODE_FUSED   = 8'h01;

  localparam int DECODE_BYTES = 15;

  localparam logic REG_EXPECTED_SOURCE = 1'b0;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_SOURCE  = 3'd1,
    PH_DEST    = 3'd2,
    PH_FUNC    = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CSUM    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_RAW_FLOW     = 3'd0,
    KIND_FUSED_FLOW   = 3'd1,
    KIND_RAW_HEIGHT   = 3'd2,
    KIND_FUSED_HEIGHT = 3'd3,
    KIND_OTHER        = 3'd4,
    KIND_CSUM_ERR     = 3'd5
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t                       kind;
    logic [DECODE_BYTES-1:0][7:0]      pay;
  } frame_t;

  typedef struct packed {
    frame_kind_t        kind;
    logic [7:0]         quality;
    logic [7:0]         light;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic signed [15:0] flow_x_fixed;
    logic signed [15:0] flow_y_fixed;
    logic [15:0]        altitude;
  } result_t;

endpackage

// File: rtl/ofp_fifo.sv
// Small first-in first-out queue with a registered storage array.
module ofp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ofp_front.sv
// Byte parser: frame sync, checksum, payload store and frame classification.
module ofp_front
  import ofp_pkg::*;
#(
  parameter int STORED_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic [7:0] expected_source,
  output logic       frame_push,
  output frame_t     frame
);

  localparam int IW = $clog2(STORED_BYTES);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [7:0] payload_count;
  logic [7:0] payload_count_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] function_code;
  logic [7:0] function_code_next;
  logic [7:0] payload_store [STORED_BYTES];
  logic       store_wr;
  logic [DECODE_BYTES-1:0][7:0] snap;

  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        PH_SYNC:    phase_next = (rx_byte == SYNC_BYTE) ? PH_SOURCE : PH_SYNC;
        PH_SOURCE:  phase_next = (rx_byte == expected_source) ? PH_DEST : PH_SYNC;
        PH_DEST:    phase_next = PH_FUNC;
        PH_FUNC:    phase_next = PH_LEN;
        PH_LEN:     phase_next = PH_PAYLOAD;
        PH_PAYLOAD: begin
          if (bytes_left == 8'd0) begin
            phase_next = PH_SYNC;
          end else if (bytes_left == 8'd1) begin
            phase_next = PH_CSUM;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_CSUM:    phase_next = PH_SYNC;
        default:    phase_next = PH_SYNC;
      endcase
    end
  end

  always_comb begin
    bytes_left_next    = bytes_left;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    function_code_next = function_code;
    store_wr           = 1'b0;
    frame_push         = 1'b0;
    if (take) begin
      case (phase)
        PH_SYNC: begin
          if (rx_byte == SYNC_BYTE) begin
            running_sum_next = rx_byte;
          end
        end
        PH_SOURCE: begin
          if (rx_byte == expected_source) begin
            running_sum_next = running_sum + rx_byte;
          end
        end
        PH_DEST: begin
          running_sum_next = running_sum + rx_byte;
        end
        PH_FUNC: begin
          function_code_next = rx_byte;
          running_sum_next   = running_sum + rx_byte;
        end
        PH_LEN: begin
          bytes_left_next    = rx_byte;
          payload_count_next = 8'd0;
          running_sum_next   = running_sum + rx_byte;
        end
        PH_PAYLOAD: begin
          if (bytes_left != 8'd0) begin
            bytes_left_next    = bytes_left - 8'd1;
            payload_count_next = payload_count + 8'd1;
            running_sum_next   = running_sum + rx_byte;
            store_wr           = (payload_count < 8'(STORED_BYTES));
          end
        end
        PH_CSUM: begin
          store_wr   = (payload_count < 8'(STORED_BYTES));
          frame_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      bytes_left    <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      function_code <= '0;
      for (int i = 0; i < STORED_BYTES; i++) begin
        payload_store[i] <= '0;
      end
    end else begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      function_code <= function_code_next;
      if (store_wr) begin
        payload_store[payload_count[IW-1:0]] <= rx_byte;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DECODE_BYTES; i++) begin
      snap[i] = (payload_count == 8'(i)) ? rx_byte : payload_store[i];
    end
  end

  always_comb begin
    frame.pay = snap;
    if (running_sum != rx_byte) begin
      frame.kind = KIND_CSUM_ERR;
    end else if (function_code == FUNC_FLOW && snap[0] == MODE_RAW) begin
      frame.kind = KIND_RAW_FLOW;
    end else if (function_code == FUNC_FLOW && snap[0] == MODE_FUSED) begin
      frame.kind = KIND_FUSED_FLOW;
    end else if (function_code == FUNC_HEIGHT && snap[0] == MODE_RAW) begin
      frame.kind = KIND_RAW_HEIGHT;
    end else if (function_code == FUNC_HEIGHT && snap[0] == MODE_FUSED) begin
      frame.kind = KIND_FUSED_HEIGHT;
    end else begin
      frame.kind = KIND_OTHER;
    end
  end

endmodule

// File: rtl/ofp_back.sv
// Field decoder for classified frames, with the result queue.
module ofp_back
  import ofp_pkg::*;
#(
  parameter int RESULT_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    frame_valid,
  input  frame_t  frame,
  output logic    frame_pop,
  input  logic    res_pop,
  output logic    res_empty,
  output result_t res
);

  result_t dec;
  logic    res_full;

  assign frame_pop = frame_valid && !res_full;

  always_comb begin
    dec      = '0;
    dec.kind = frame.kind;
    case (frame.kind)
      KIND_RAW_FLOW: begin
        dec.quality = frame.pay[1];
        dec.flow_x  = {{8{frame.pay[2][7]}}, frame.pay[2]};
        dec.flow_y  = {{8{frame.pay[3][7]}}, frame.pay[3]};
        dec.light   = frame.pay[4];
      end
      KIND_FUSED_FLOW: begin
        dec.quality      = frame.pay[1];
        dec.flow_x       = {frame.pay[2], frame.pay[3]};
        dec.flow_y       = {frame.pay[4], frame.pay[5]};
        dec.flow_x_fixed = {frame.pay[6], frame.pay[7]};
        dec.flow_y_fixed = {frame.pay[8], frame.pay[9]};
        dec.light        = frame.pay[14];
      end
      KIND_RAW_HEIGHT, KIND_FUSED_HEIGHT: begin
        dec.altitude = {frame.pay[1], frame.pay[2]};
      end
      default: begin
      end
    endcase
  end

  ofp_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (frame_pop),
    .wr_data(dec),
    .rd_en  (res_pop),
    .rd_data(res),
    .full   (res_full),
    .empty  (res_empty)
  );

endmodule

// File: rtl/optical_flow_frame_parser_unit.sv
// Top level of the optical-flow sensor frame parser.
//
//   channel   handshake            payload
//   input     push / full          rx_byte
//   result    empty / pop          frame_kind, quality, light, flow_x, flow_y,
//                                  flow_x_fixed, flow_y_fixed, altitude
//   config    psel/penable/pwrite  paddr, pwdata, prdata (expected_source)
//
// One byte is taken every cycle while push is high and full is low; the parser
// state updates in the cycle of the byte. A checksum byte lands a classified frame
// in a two-entry frame queue; when the result queue is not full, the decoder moves
// it to a two-entry result queue. full rises only while the frame queue is full.
// Reset clears the parser state, the payload store and both queues.
module optical_flow_frame_parser_unit
  import ofp_pkg::*;
#(
  parameter int STORED_BYTES = 15,
  parameter int FRAME_DEPTH  = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         frame_kind,
  output logic [7:0]         quality,
  output logic [7:0]         light,
  output logic signed [15:0] flow_x,
  output logic signed [15:0] flow_y,
  output logic signed [15:0] flow_x_fixed,
  output logic signed [15:0] flow_y_fixed,
  output logic [15:0]        altitude,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       take;
  logic [7:0] expected_source;
  logic       frame_push;
  frame_t     frame_in;
  frame_t     frame_head;
  logic       frame_empty;
  logic       frame_pop;
  result_t    res;

  assign pready = 1'b1;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_source <= SOURCE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_EXPECTED_SOURCE) begin
      expected_source <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_EXPECTED_SOURCE) ? {24'd0, expected_source} : 32'd0;

  ofp_front #(
    .STORED_BYTES(STORED_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .rx_byte        (rx_byte),
    .expected_source(expected_source),
    .frame_push     (frame_push),
    .frame          (frame_in)
  );

  ofp_fifo #(
    .WIDTH($bits(frame_t)),
    .DEPTH(FRAME_DEPTH)
  ) u_frame_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (frame_push),
    .wr_data(frame_in),
    .rd_en  (frame_pop),
    .rd_data(frame_head),
    .full   (full),
    .empty  (frame_empty)
  );

  ofp_back #(
    .RESULT_DEPTH(RESULT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(!frame_empty),
    .frame      (frame_head),
    .frame_pop  (frame_pop),
    .res_pop    (pop),
    .res_empty  (empty),
    .res        (res)
  );

  assign frame_kind   = res.kind;
  assign quality      = res.quality;
  assign light        = res.light;
  assign flow_x       = res.flow_x;
  assign flow_y       = res.flow_y;
  assign flow_x_fixed = res.flow_x_fixed;
  assign flow_y_fixed = res.flow_y_fixed;
  assign altitude     = res.altitude;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the optical-flow frame parser: directed frames, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofp_pkg::*;

  localparam int STORED = 15;
  localparam logic [2:0] SRC_ADDR = 3'(4 * REG_EXPECTED_SOURCE);
  localparam int PHASE_BYTES = 300;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_SRC,
    FR_ZERO_LEN,
    FR_NOISE
  } shape_t;

  typedef struct packed {
    shape_t     shape;
    logic [7:0] src;
    logic [7:0] func;
    logic [7:0] len;
    logic [119:0] pay;
    bit         typed;
    result_t    want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] b;
    bit         typed;
    result_t    want;
  } rx_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic full, empty, pready;
  logic [2:0] frame_kind;
  logic [7:0] quality, light;
  logic signed [15:0] flow_x, flow_y, flow_x_fixed, flow_y_fixed;
  logic [15:0] altitude;
  logic [31:0] prdata;

  rx_req_t tx_q[$];
  result_t decoded_due[$];
  int errors = 0;
  int bytes_queued = 0;

  int burst_left = 0;
  int gap_left = 0;
  bit send_gaps = 1'b1;
  int pop_pct = 70;
  bit hold_req = 1'b0;
  int hold_left = 0;

  logic [7:0] cfg_source;
  phase_t ps_phase;
  logic [7:0] ps_left, ps_count, ps_sum, ps_func;
  logic [7:0] ps_store [STORED];

  dir_row_t dir_tab [19] = '{
    '{FR_NOISE, 8'h22, 8'h00, 8'd4, 120'h00FF553300_0000000000_0000000000, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h51, 8'd5, 120'h00FF807FFF_0000000000_0000000000, 1'b1,
      '{KIND_RAW_FLOW, 8'hFF, 8'hFF, 16'hFF80, 16'h007F, 16'h0, 16'h0, 16'h0}},
    '{FR_GOOD, 8'h22, 8'h51, 8'd5, 120'h00007F8000_0000000000_0000000000, 1'b1,
      '{KIND_RAW_FLOW, 8'h00, 8'h00, 16'h007F, 16'hFF80, 16'h0, 16'h0, 16'h0}},
    '{FR_GOOD, 8'h22, 8'h51, 8'd15, 120'h01A580007F_FF1234FFFE_000000005A, 1'b1,
      '{KIND_FUSED_FLOW, 8'hA5, 8'h5A, 16'h8000, 16'h7FFF, 16'h1234, 16'hFFFE, 16'h0}},
    '{FR_GOOD, 8'h22, 8'h52, 8'd3, 120'h00FFFF0000_0000000000_0000000000, 1'b1,
      '{KIND_RAW_HEIGHT, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF}},
    '{FR_GOOD, 8'h22, 8'h52, 8'd3, 120'h0100010000_0000000000_0000000000, 1'b1,
      '{KIND_FUSED_HEIGHT, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001}},
    '{FR_GOOD, 8'h22, 8'h51, 8'd1, 120'h0200000000_0000000000_0000000000, 1'b1,
      '{KIND_OTHER, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
    '{FR_GOOD, 8'h22, 8'h00, 8'd2, 120'h0000000000_0000000000_0000000000, 1'b1,
      '{KIND_OTHER, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
    '{FR_GOOD, 8'h22, 8'hFF, 8'd1, 120'h0100000000_0000000000_0000000000, 1'b1,
      '{KIND_OTHER, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
    '{FR_BAD_SUM, 8'h22, 8'h51, 8'd5, 120'h00FF807FFF_0000000000_0000000000, 1'b1,
      '{KIND_CSUM_ERR, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
    '{FR_BAD_SRC, 8'hAA, 8'h51, 8'd3, 120'h0011220000_0000000000_0000000000, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h52, 8'd2, 120'h0112340000_0000000000_0000000000, 1'b0, '0},
    '{FR_ZERO_LEN, 8'h22, 8'h51, 8'd0, 120'hAA00000000_0000000000_0000000000, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h51, 8'd1, 120'h0000000000_0000000000_0000000000, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h51, 8'd255, 120'h0180017FFF_8000123456_789ABCDEF0, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h51, 8'd14, 120'h017F00FF01_2345678000_7FFF0000FF, 1'b0, '0},
    '{FR_GOOD, 8'h22, 8'h51, 8'd16, 120'h0011223344_5566778899_AABBCCDDEE, 1'b0, '0},
    '{FR_BAD_SUM, 8'h22, 8'h52, 8'd3, 120'h0100000000_0000000000_0000000000, 1'b1,
      '{KIND_CSUM_ERR, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
    '{FR_BAD_SRC, 8'h21, 8'h52, 8'd1, 120'h0100000000_0000000000_0000000000, 1'b0, '0}
  };

  optical_flow_frame_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .frame_kind   (frame_kind),
    .quality      (quality),
    .light        (light),
    .flow_x       (flow_x),
    .flow_y       (flow_y),
    .flow_x_fixed (flow_x_fixed),
    .flow_y_fixed (flow_y_fixed),
    .altitude     (altitude),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] stored_at(int i);
    return (i < STORED) ? ps_store[i] : 8'h00;
  endfunction

  function automatic logic [15:0] stored_word(int i);
    return {stored_at(i), stored_at(i + 1)};
  endfunction

  function automatic result_t decode_frame(bit good);
    result_t r;
    logic [7:0] mode;
    logic [7:0] fx_b;
    logic [7:0] fy_b;
    r = '0;
    mode = stored_at(0);
    if (!good) begin
      r.kind = KIND_CSUM_ERR;
    end else if (ps_func == FUNC_FLOW && mode == MODE_RAW) begin
      fx_b = stored_at(2);
      fy_b = stored_at(3);
      r.kind = KIND_RAW_FLOW;
      r.quality = stored_at(1);
      r.flow_x = {{8{fx_b[7]}}, fx_b};
      r.flow_y = {{8{fy_b[7]}}, fy_b};
      r.light = stored_at(4);
    end else if (ps_func == FUNC_FLOW && mode == MODE_FUSED) begin
      r.kind = KIND_FUSED_FLOW;
      r.quality = stored_at(1);
      r.flow_x = stored_word(2);
      r.flow_y = stored_word(4);
      r.flow_x_fixed = stored_word(6);
      r.flow_y_fixed = stored_word(8);
      r.light = stored_at(14);
    end else if (ps_func == FUNC_HEIGHT && (mode == MODE_RAW || mode == MODE_FUSED)) begin
      r.kind = (mode == MODE_RAW) ? KIND_RAW_HEIGHT : KIND_FUSED_HEIGHT;
      r.altitude = stored_word(1);
    end else begin
      r.kind = KIND_OTHER;
    end
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit done;
    done = 1'b0;
    r = '0;
    case (ps_phase)
      PH_SYNC: begin
        if (b == SYNC_BYTE) begin
          ps_phase = PH_SOURCE;
          ps_sum = b;
        end
      end
      PH_SOURCE: begin
        if (b == cfg_source) begin
          ps_phase = PH_DEST;
          ps_sum = ps_sum + b;
        end else begin
          ps_phase = PH_SYNC;
        end
      end
      PH_DEST: begin
        ps_phase = PH_FUNC;
        ps_sum = ps_sum + b;
      end
      PH_FUNC: begin
        ps_phase = PH_LEN;
        ps_func = b;
        ps_sum = ps_sum + b;
      end
      PH_LEN: begin
        ps_phase = PH_PAYLOAD;
        ps_left = b;
        ps_count = 8'h00;
        ps_sum = ps_sum + b;
      end
      PH_PAYLOAD: begin
        if (ps_left == 8'h00) begin
          ps_phase = PH_SYNC;
        end else begin
          ps_left = ps_left - 8'h01;
          if (ps_count < STORED) ps_store[ps_count] = b;
          ps_count = ps_count + 8'h01;
          ps_sum = ps_sum + b;
          if (ps_left == 8'h00) ps_phase = PH_CSUM;
        end
      end
      PH_CSUM: begin
        ps_phase = PH_SYNC;
        if (ps_count < STORED) ps_store[ps_count] = b;
        r = decode_frame(ps_sum == b);
        done = 1'b1;
      end
      default: ps_phase = PH_SYNC;
    endcase
    return done;
  endfunction

  task automatic add_frame(input shape_t shape, input logic [7:0] src, input logic [7:0] func,
                           input logic [7:0] len, input logic [119:0] pay, input bit typed,
                           input result_t want, input bit avoid_sync);
    logic [7:0] seq[$];
    logic [7:0] dst, sum;
    rx_req_t req;
    int i;
    if (shape == FR_NOISE) begin
      for (i = 0; i < len; i++) seq.push_back((i < STORED) ? pay[119 - 8 * i -: 8] : 8'($urandom));
    end else begin
      dst = 8'($urandom);
      if (avoid_sync && dst == SYNC_BYTE) dst = 8'h00;
      seq = '{SYNC_BYTE, src, dst, func};
      if (shape == FR_ZERO_LEN) begin
        seq.push_back(8'h00);
        seq.push_back(pay[119 -: 8]);
      end else begin
        seq.push_back(len);
        for (i = 0; i < len; i++) seq.push_back((i < STORED) ? pay[119 - 8 * i -: 8] : 8'($urandom));
        if (shape != FR_BAD_SRC) begin
          sum = 8'h00;
          foreach (seq[k]) sum = sum + seq[k];
          seq.push_back((shape == FR_BAD_SUM) ? sum + 8'h01 : sum);
        end
      end
    end
    foreach (seq[k]) begin
      req.b = seq[k];
      req.typed = typed && (k == seq.size() - 1);
      req.want = want;
      tx_q.push_back(req);
    end
    bytes_queued += seq.size();
  endtask

  task automatic apb_write(input logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = SRC_ADDR;
    pwdata = {24'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_source = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_check(input logic [7:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = SRC_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== {24'h0, want}) begin
      $display("%0t: expected_source readback mismatch, expected %h, got %h", $time,
               {24'h0, want}, got);
      errors++;
    end
  endtask

  task automatic drain();
    while (tx_q.size() != 0 || decoded_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      push <= 1'b0;
      rx_byte <= 8'($urandom);
      gap_left--;
    end else if (tx_q.size() > 0) begin
      push <= 1'b1;
      rx_byte <= tx_q[0].b;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left = send_gaps ? $urandom_range(0, 8) : 0;
      end else begin
        burst_left--;
      end
    end else begin
      push <= 1'b0;
      rx_byte <= 8'($urandom);
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  always @(posedge clk) begin : monitor
    rx_req_t req;
    result_t pred, want;
    if (!rst) begin
      if (push && !full && tx_q.size() > 0) begin
        req = tx_q.pop_front();
        if (parse_byte(rx_byte, pred)) decoded_due.push_back(req.typed ? req.want : pred);
      end
      if (pop && !empty) begin
        if (decoded_due.size() == 0) begin
          $display("%0t: result with nothing expected, kind %h", $time, frame_kind);
          errors++;
        end else begin
          want = decoded_due.pop_front();
          check_field("frame_kind", 16'(want.kind), 16'(frame_kind));
          check_field("quality", 16'(want.quality), 16'(quality));
          check_field("light", 16'(want.light), 16'(light));
          check_field("flow_x", want.flow_x, flow_x);
          check_field("flow_y", want.flow_y, flow_y);
          check_field("flow_x_fixed", want.flow_x_fixed, flow_x_fixed);
          check_field("flow_y_fixed", want.flow_y_fixed, flow_y_fixed);
          check_field("altitude", want.altitude, altitude);
        end
      end
    end
  end

  initial begin : main
    logic [7:0] phase_src [5];
    bit phase_gaps [5];
    int phase_pop [5];
    logic [127:0] rnd;
    logic [119:0] pay;
    logic [7:0] func, len, src;
    shape_t shape;
    int start, sel;
    phase_src = '{8'h00, 8'hFF, SYNC_BYTE, 8'($urandom), SOURCE_RESET};
    phase_gaps = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_pop = '{100, 100, 40, 60, 85};
    cfg_source = SOURCE_RESET;
    ps_phase = PH_SYNC;
    ps_left = 8'h00;
    ps_count = 8'h00;
    ps_sum = 8'h00;
    ps_func = 8'h00;
    foreach (ps_store[k]) ps_store[k] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    apb_read_check(SOURCE_RESET);
    foreach (dir_tab[i]) begin
      add_frame(dir_tab[i].shape, dir_tab[i].src, dir_tab[i].func, dir_tab[i].len,
                dir_tab[i].pay, dir_tab[i].typed, dir_tab[i].want, 1'b1);
    end
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      apb_write(phase_src[ph]);
      apb_read_check(phase_src[ph]);
      send_gaps = phase_gaps[ph];
      pop_pct = phase_pop[ph];
      if (ph == 0) hold_req = 1'b1;
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) begin
        sel = $urandom_range(0, 99);
        shape = (sel < 70) ? FR_GOOD : (sel < 80) ? FR_BAD_SUM : (sel < 87) ? FR_BAD_SRC :
                (sel < 92) ? FR_ZERO_LEN : FR_NOISE;
        sel = $urandom_range(0, 99);
        func = (sel < 40) ? FUNC_FLOW : (sel < 80) ? FUNC_HEIGHT : 8'($urandom);
        sel = $urandom_range(0, 99);
        len = (sel < 85) ? 8'($urandom_range(1, 16)) :
              (sel < 97) ? 8'($urandom_range(17, 40)) : 8'($urandom_range(41, 255));
        if (shape == FR_NOISE) len = 8'($urandom_range(1, 8));
        rnd = {$urandom, $urandom, $urandom, $urandom};
        pay = rnd[119:0];
        sel = $urandom_range(0, 99);
        pay[119:112] = (sel < 45) ? MODE_RAW : (sel < 90) ? MODE_FUSED : 8'($urandom);
        src = (shape == FR_BAD_SRC) ? cfg_source ^ 8'($urandom_range(1, 255)) : cfg_source;
        add_frame(shape, src, func, len, pay, 1'b0, '0, 1'b0);
      end
      drain();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ofp_pkg.sv
rtl/ofp_fifo.sv
rtl/ofp_front.sv
rtl/ofp_back.sv
rtl/optical_flow_frame_parser_unit.sv
verif/tb.sv
